/* src/ctik_pkg.sv */
package ctik_pkg;

  localparam int AXES   = 3;
  localparam int COEF_W = 18;
  localparam int ROW_W  = AXES * COEF_W;

  localparam logic [2:0] CFG_ABS_MODE = 3'd0;
  localparam logic [2:0] CFG_RATE     = 3'd1;
  localparam logic [2:0] CFG_JAC_ROW0 = 3'd2;
  localparam logic [2:0] CFG_JAC_ROW1 = 3'd3;
  localparam logic [2:0] CFG_JAC_ROW2 = 3'd4;

  localparam logic        ACT_LOAD = 1'b0;
  localparam logic        ACT_TICK = 1'b1;

  localparam logic [16:0] ONE_Q16    = 17'h10000;
  localparam logic [16:0] REV_SCALE  = 17'd60;
  localparam logic [15:0] RATE_RESET = 16'd100;
  localparam logic [53:0] JAC_UNIT   = 54'd4096;

  typedef struct packed {
    logic load;
    logic mul;
    logic fin;
  } ctik_axis_ctl_t;

  typedef struct packed {
    logic       en;
    logic [1:0] phase;
    logic       rev;
  } ctik_map_ctl_t;

endpackage

/* src/ctik_in_if.sv */
interface ctik_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  logic [15:0]        step_count;

  modport source (output valid, action, target_x, target_y, target_z, step_count,
                  input ready);
  modport sink (input valid, action, target_x, target_y, target_z, step_count,
                output ready);
endinterface

/* src/ctik_out_if.sv */
interface ctik_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [31:0] pose_z;
  logic signed [47:0] speed_a;
  logic signed [47:0] speed_b;
  logic signed [47:0] speed_c;
  logic signed [47:0] rev_a;
  logic signed [47:0] rev_b;
  logic signed [47:0] rev_c;
  logic               final_step;

  modport source (output valid, pose_x, pose_y, pose_z, speed_a, speed_b, speed_c,
                  rev_a, rev_b, rev_c, final_step, input ready);
  modport sink (input valid, pose_x, pose_y, pose_z, speed_a, speed_b, speed_c,
                rev_a, rev_b, rev_c, final_step, output ready);
endinterface

/* src/ctik_div.sv */
module ctik_div import ctik_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [16:0] quot_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [15:0] rem_q, dvs_q;
  logic [31:0] dvd_q;
  logic [16:0] trial;
  logic        qbit;
  logic [16:0] diff;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, dvd_q[31]};
  assign qbit  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      dvd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        dvd_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= qbit ? diff[15:0] : trial[15:0];
        dvd_q <= {dvd_q[30:0], qbit};
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q[16:0];

endmodule

/* src/ctik_axis.sv */
module ctik_axis import ctik_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctik_axis_ctl_t     ctl_i,
  input  logic signed [31:0] target_i,
  input  logic [16:0]        s_i,
  output logic signed [31:0] pose_o,
  output logic signed [32:0] delta_o
);

  logic signed [31:0] start_q, goal_q, cur_q;
  logic signed [50:0] prod_q;
  logic signed [32:0] delta_q;
  logic signed [32:0] diff;
  logic signed [17:0] s_sgn;
  logic signed [50:0] step_sh;
  logic signed [31:0] pose_n;

  assign diff    = 33'(goal_q) - 33'(start_q);
  assign s_sgn   = signed'({1'b0, s_i});
  assign step_sh = prod_q >>> 16;
  // pose stays between start and goal, so a 32-bit add is exact
  assign pose_n  = start_q + step_sh[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      goal_q  <= '0;
      cur_q   <= '0;
    end else begin
      if (ctl_i.load) begin
        goal_q  <= target_i;
        start_q <= cur_q;
      end
      if (ctl_i.fin) begin
        cur_q <= pose_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      prod_q <= diff * s_sgn;
    end
    if (ctl_i.fin) begin
      delta_q <= 33'(pose_n) - 33'(cur_q);
    end
  end

  assign pose_o  = cur_q;
  assign delta_o = delta_q;

endmodule

/* src/ctik_motor.sv */
module ctik_motor import ctik_pkg::*; (
  input  logic               clk_i,
  input  ctik_map_ctl_t      ctl_i,
  input  logic [ROW_W-1:0]   row_i,
  input  logic signed [32:0] v_i [AXES],
  input  logic signed [16:0] f_i,
  output logic signed [47:0] spd_o,
  output logic signed [47:0] rev_o
);

  logic signed [50:0] prod_q [AXES];
  logic signed [52:0] acc_q;
  logic signed [43:0] ph_q, pl_q;
  logic signed [47:0] spd_q, rev_q;
  logic signed [COEF_W-1:0] coef [AXES];
  logic signed [70:0] tot;
  logic signed [47:0] res;

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      coef[k] = signed'(row_i[k*COEF_W +: COEF_W]);
    end
  end

  // acc*f split in two halves to keep each multiply narrow
  assign tot = (71'(ph_q) <<< 26) + 71'(pl_q);

  always_comb begin
    if (tot[70:59] == {12{tot[70]}}) begin
      res = tot[59:12];
    end else if (tot[70]) begin
      res = {1'b1, 47'd0};
    end else begin
      res = {1'b0, {47{1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      case (ctl_i.phase)
        2'd0: begin
          for (int k = 0; k < AXES; k++) begin
            prod_q[k] <= coef[k] * v_i[k];
          end
        end
        2'd1: acc_q <= 53'(prod_q[0]) + 53'(prod_q[1]) + 53'(prod_q[2]);
        2'd2: begin
          ph_q <= signed'(acc_q[52:26]) * f_i;
          pl_q <= signed'({1'b0, acc_q[25:0]}) * f_i;
        end
        2'd3: begin
          if (ctl_i.rev) rev_q <= res;
          else spd_q <= res;
        end
        default: ;
      endcase
    end
  end

  assign spd_o = spd_q;
  assign rev_o = rev_q;

endmodule

/* src/cubic_trajectory_inverse_kinematics_top.sv */
// Cubic (smoothstep) trajectory generator with an inverse-Jacobian map to three
// motors. A load word (action 0) stores the target and step count and starts the
// move from the current pose; each tick word (action 1) during a move yields one
// result word with pose, speed, rev and a last-step flag. A tick passes through
// the bit-serial divider forming u = t/N (32 steps and its done flag), the
// smoothstep states (square, cube, blend), the per-axis pose lanes (multiply,
// finish), the motor lanes (speed phases, then rev phases) and the result
// register load, which waits while the previous result word is not taken. Loads
// and idle ticks are taken in the idle state. Ticks outside a move give no result.
module cubic_trajectory_inverse_kinematics_top import ctik_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ctik_in_if.sink     in_i,
  ctik_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [53:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_SQ, S_CU, S_SS, S_PMUL, S_PFIN, S_MAP, S_OUT
  } state_e;

  state_e state_q;

  logic        abs_q;
  logic [15:0] rate_q;
  logic [ROW_W-1:0] jac_q [AXES];

  logic [15:0] idx_q, total_q, t_q;
  logic        moving_q;
  logic [16:0] u_q, u2_q, u3_q, s_q;
  logic [2:0]  map_ph_q;

  logic               out_valid_q;
  logic signed [31:0] o_pose_q [AXES];
  logic signed [47:0] o_spd_q [AXES];
  logic signed [47:0] o_rev_q [AXES];
  logic               o_final_q;

  logic in_acc, tick_go, div_done;
  logic [16:0] quot;
  logic [33:0] sq_w, cu_w;
  logic [19:0] s_a, s_b, s_w;
  logic signed [31:0] target [AXES];
  logic signed [31:0] pose [AXES];
  logic signed [32:0] delta [AXES];
  logic signed [32:0] v_sel [AXES];
  logic signed [47:0] spd [AXES];
  logic signed [47:0] rev [AXES];
  logic signed [16:0] factor;
  ctik_axis_ctl_t axis_ctl;
  ctik_map_ctl_t  map_ctl;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc  = in_i.valid && in_i.ready;
  assign tick_go = in_acc && (in_i.action == ACT_TICK) && moving_q && (total_q != 16'd0);

  ctik_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (tick_go),
    .dividend_i ({idx_q + 16'd1, 16'd0}),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign sq_w = u_q * u_q;
  assign cu_w = u2_q * u_q;
  assign s_a  = {3'b0, u2_q} + {2'b0, u2_q, 1'b0};
  assign s_b  = {2'b0, u3_q, 1'b0};
  assign s_w  = s_a - s_b;

  assign target[0] = in_i.target_x;
  assign target[1] = in_i.target_y;
  assign target[2] = in_i.target_z;

  assign axis_ctl.load = in_acc && (in_i.action == ACT_LOAD);
  assign axis_ctl.mul  = (state_q == S_PMUL);
  assign axis_ctl.fin  = (state_q == S_PFIN);

  assign map_ctl.en    = (state_q == S_MAP);
  assign map_ctl.phase = map_ph_q[1:0];
  assign map_ctl.rev   = map_ph_q[2];

  assign factor = map_ctl.rev ? signed'(REV_SCALE) : signed'({1'b0, rate_q});

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      v_sel[k] = (map_ctl.rev && abs_q) ? 33'(pose[k]) : delta[k];
    end
  end

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    ctik_axis u_axis (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (axis_ctl),
      .target_i (target[g]),
      .s_i      (s_q),
      .pose_o   (pose[g]),
      .delta_o  (delta[g])
    );

    ctik_motor u_motor (
      .clk_i (clk_i),
      .ctl_i (map_ctl),
      .row_i (jac_q[g]),
      .v_i   (v_sel),
      .f_i   (factor),
      .spd_o (spd[g]),
      .rev_o (rev[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      abs_q       <= 1'b0;
      rate_q      <= RATE_RESET;
      jac_q[0]    <= JAC_UNIT;
      jac_q[1]    <= JAC_UNIT << COEF_W;
      jac_q[2]    <= JAC_UNIT << (2 * COEF_W);
      idx_q       <= '0;
      total_q     <= '0;
      t_q         <= '0;
      moving_q    <= 1'b0;
      u_q         <= '0;
      u2_q        <= '0;
      u3_q        <= '0;
      s_q         <= '0;
      map_ph_q    <= '0;
      out_valid_q <= 1'b0;
      o_final_q   <= 1'b0;
      for (int k = 0; k < AXES; k++) begin
        o_pose_q[k] <= '0;
        o_spd_q[k]  <= '0;
        o_rev_q[k]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ABS_MODE: abs_q    <= cfg_data_i[0];
          CFG_RATE:     rate_q   <= cfg_data_i[15:0];
          CFG_JAC_ROW0: jac_q[0] <= cfg_data_i;
          CFG_JAC_ROW1: jac_q[1] <= cfg_data_i;
          CFG_JAC_ROW2: jac_q[2] <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && out_o.ready && state_q != S_OUT) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (axis_ctl.load) begin
            total_q  <= in_i.step_count;
            idx_q    <= '0;
            moving_q <= (in_i.step_count != 16'd0);
          end else if (tick_go) begin
            t_q     <= idx_q + 16'd1;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            u_q     <= quot;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          u2_q    <= sq_w[32:16];
          state_q <= S_CU;
        end
        S_CU: begin
          u3_q    <= cu_w[32:16];
          state_q <= S_SS;
        end
        S_SS: begin
          if (s_a < s_b) s_q <= '0;
          else if (s_w > 20'(ONE_Q16)) s_q <= ONE_Q16;
          else s_q <= s_w[16:0];
          state_q <= S_PMUL;
        end
        S_PMUL: state_q <= S_PFIN;
        S_PFIN: begin
          map_ph_q <= '0;
          state_q  <= S_MAP;
        end
        S_MAP: begin
          map_ph_q <= map_ph_q + 3'd1;
          if (map_ph_q == 3'd7) state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            for (int k = 0; k < AXES; k++) begin
              o_pose_q[k] <= pose[k];
              o_spd_q[k]  <= spd[k];
              o_rev_q[k]  <= rev[k];
            end
            o_final_q <= (t_q >= total_q);
            idx_q     <= t_q;
            if (t_q >= total_q) moving_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.pose_x     = o_pose_q[0];
  assign out_o.pose_y     = o_pose_q[1];
  assign out_o.pose_z     = o_pose_q[2];
  assign out_o.speed_a    = o_spd_q[0];
  assign out_o.speed_b    = o_spd_q[1];
  assign out_o.speed_c    = o_spd_q[2];
  assign out_o.rev_a      = o_rev_q[0];
  assign out_o.rev_b      = o_rev_q[1];
  assign out_o.rev_c      = o_rev_q[2];
  assign out_o.final_step = o_final_q;

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider done outside divide state");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result word raised outside output state");

  a_move_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(moving_q) |-> $past(state_q == S_OUT) || $past(axis_ctl.load))
    else $error("move ended without last step or load");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_i.ready)
    else $error("input ready while busy");

endmodule
